[hdl/dbvs_pkg.sv]
// Package with the shared types and constants of the diving variable selection block.
package dbvs_pkg;

  typedef struct packed {
    logic [15:0]        column_index;
    logic signed [63:0] solution_value;
    logic signed [31:0] objective_coeff;
    logic [19:0]        column_length;
    logic               is_binary;
    logic               down_locked;
    logic               up_locked;
    logic               last_item;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] best_column;
    logic        round_up;
    logic        all_trivially_roundable;
  } out_t;

  // Register indexes of the configuration port.
  localparam logic CFG_INTEGER_TOLERANCE = 1'b0;
  localparam logic CFG_MAXIMIZE          = 1'b1;

  localparam logic [22:0] TOLERANCE_RESET = 23'd17;

  // One in Q1.24.
  localparam logic [24:0] FRAC_ONE = 25'h1000000;

  // Widths of the rounding cost, of the column length plus one and of the penalized score.
  localparam int COST_W    = 56;
  localparam int DIVISOR_W = 21;
  localparam int SCORE_W   = 66;

  // The divider produces one quotient bit a cycle.
  localparam int DIV_STEPS = COST_W;

endpackage

[hdl/dbvs_div.sv]
// Restoring radix-2 divider of the rounding cost by the column length plus one.
module dbvs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [dbvs_pkg::COST_W-1:0]    dividend,
  input  logic [dbvs_pkg::DIVISOR_W-1:0] divisor,
  output logic                           done,
  output logic [dbvs_pkg::COST_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(dbvs_pkg::DIV_STEPS);
  localparam int RW    = dbvs_pkg::DIVISOR_W;
  localparam int QW    = dbvs_pkg::COST_W;

  logic [RW-1:0]    rem;
  logic [QW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [RW+1:0]    trial;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial = {1'b0, rem, quo[QW-1]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(dbvs_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!trial[RW+1]) begin
        rem <= trial[RW-1:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= {rem[RW-2:0], quo[QW-1]};
        quo <= {quo[QW-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

[hdl/dive_branch_variable_select.sv]
// Top level of the vector-length diving variable selection block.
// A variable that does not compete is transferred in the idle state. A competing binary variable
// holds the input through transfer, multiply, the divider steps up to done, and compare.
// A non-binary one adds the two penalty steps. The last item of a batch then goes to the
// finish state to load the result register, waiting while the previous result is not taken.
// Synchronous active-high reset rst restores the control state and starts an empty batch.
module dive_branch_variable_select (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dbvs_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dbvs_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [22:0]     cfg_data
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PEN1 = 3'd3;
  localparam logic [2:0] S_PEN2 = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam int CW = dbvs_pkg::COST_W;
  localparam int SW = dbvs_pkg::SCORE_W;

  logic [2:0] state;
  logic [2:0] state_next;

  // Configuration registers.
  logic [22:0] integer_tolerance;
  logic        maximize;

  // Batch state.
  logic [63:0] best_score;
  logic [15:0] best_col;
  logic        best_up;
  logic        have_best;
  logic        trivial_so_far;

  // The item under work.
  logic [15:0]                    cur_col;
  logic [24:0]                    cur_mult;
  logic [31:0]                    cur_mag;
  logic [dbvs_pkg::DIVISOR_W-1:0] cur_divisor;
  logic                           cur_up;
  logic                           cur_binary;
  logic                           cur_last;
  logic [SW-1:0]                  work;

  // Fractionality and rounding direction of the incoming variable.
  logic [23:0] frac;
  logic [24:0] frac_up;
  logic [24:0] frac_dist;
  logic        fractional;
  logic        both_locked;
  logic        candidate;
  logic signed [32:0] coef;
  logic signed [32:0] obj;
  logic signed [32:0] obj_neg;
  logic        up;
  logic        in_xfer;

  logic [56:0]   product;
  logic          div_start;
  logic          div_done;
  logic [CW-1:0] div_quo;
  logic [SW-1:0] quo_wide;
  logic [63:0]   score;
  logic          score_wins;

  assign frac        = in_data.solution_value[23:0];
  assign frac_up     = dbvs_pkg::FRAC_ONE - {1'b0, frac};
  assign frac_dist   = ({1'b0, frac} < frac_up) ? {1'b0, frac} : frac_up;
  assign fractional  = frac_dist > {2'b00, integer_tolerance};
  assign both_locked = in_data.down_locked && in_data.up_locked;
  assign candidate   = fractional && (trivial_so_far || both_locked);

  // Sign-extend the coefficient and apply the objective sense. The rounding
  // cost is the distance to the chosen integer times the coefficient magnitude.
  assign coef    = {in_data.objective_coeff[31], in_data.objective_coeff};
  assign obj     = maximize ? -coef : coef;
  assign obj_neg = -obj;
  assign up      = !obj[32];

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // The product is registered inside the divider when it starts.
  assign product   = {32'b0, cur_mult} * {25'b0, cur_mag};
  assign div_start = (state == S_MUL);

  dbvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product[CW-1:0]),
    .divisor  (cur_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign quo_wide = {{(SW-CW){1'b0}}, div_quo};

  // A penalized score that no longer fits in 64 bits saturates to all ones.
  assign score      = (|work[SW-1:64]) ? '1 : work[63:0];
  assign score_wins = !have_best || (score < best_score);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (candidate) begin
            state_next = S_MUL;
          end else if (in_data.last_item) begin
            state_next = S_FIN;
          end
        end
      end
      S_MUL: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = cur_binary ? S_CMP : S_PEN1;
        end
      end
      S_PEN1: begin
        state_next = S_PEN2;
      end
      S_PEN2: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        state_next = cur_last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      integer_tolerance <= dbvs_pkg::TOLERANCE_RESET;
      maximize          <= 1'b0;
      best_score        <= '1;
      best_col          <= '0;
      best_up           <= 1'b0;
      have_best         <= 1'b0;
      trivial_so_far    <= 1'b1;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          dbvs_pkg::CFG_INTEGER_TOLERANCE: integer_tolerance <= cfg_data;
          dbvs_pkg::CFG_MAXIMIZE:          maximize          <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // The first competing variable locked both ways restarts the search.
      if (in_xfer && candidate && trivial_so_far && both_locked) begin
        trivial_so_far <= 1'b0;
        best_score     <= '1;
        have_best      <= 1'b0;
      end

      // The earlier variable keeps a tie.
      if (state == S_CMP && score_wins) begin
        have_best  <= 1'b1;
        best_score <= score;
        best_col   <= cur_col;
        best_up    <= cur_up;
      end

      // Hand the result to the output register and open a new batch.
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid      <= 1'b1;
        best_score     <= '1;
        best_col       <= '0;
        best_up        <= 1'b0;
        have_best      <= 1'b0;
        trivial_so_far <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_col     <= in_data.column_index;
      cur_mult    <= up ? frac_up : {1'b0, frac};
      cur_mag     <= up ? obj[31:0] : obj_neg[31:0];
      cur_divisor <= {1'b0, in_data.column_length} + 21'd1;
      cur_up      <= up;
      cur_binary  <= in_data.is_binary;
      cur_last    <= in_data.last_item;
    end

    // Times 1000 as times 1024 less times 16 less times 8.
    case (state)
      S_DIV:   work <= quo_wide;
      S_PEN1:  work <= (quo_wide << 10) - (quo_wide << 4);
      S_PEN2:  work <= work - (quo_wide << 3);
      default: work <= work;
    endcase

    if (state == S_FIN && (!out_valid || out_ready)) begin
      out_data.found                   <= have_best;
      out_data.best_column             <= have_best ? best_col : 16'd0;
      out_data.round_up                <= have_best && best_up;
      out_data.all_trivially_roundable <= trivial_so_far;
    end
  end

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  // Without a held best the running score is at its maximum.
  assert property (@(posedge clk) disable iff (rst) !have_best |-> best_score == '1)
    else $error("best score set without a held best");

  // Trivial roundability is lost only at the transfer of an input item.
  assert property (@(posedge clk) disable iff (rst)
    $fell(trivial_so_far) |-> $past(in_valid && in_ready))
    else $error("trivial flag cleared without an input transfer");

  // The rounding cost always fits the divider.
  assert property (@(posedge clk) disable iff (rst) div_start |-> product[56] == 1'b0)
    else $error("rounding cost exceeds the divider width");

endmodule
